@@ rtl/core/crml_pkg.sv @@
package crml_pkg;

   // fixed field widths
   localparam int POS_W     = 48;
   localparam int MASS_W    = 56;
   localparam int MO_W      = 57;
   localparam int CMD_W     = 3;
   localparam int STAT_W    = 2;
   localparam int REQ_DW    = 200;
   localparam int RSP_DW    = 112;
   localparam int MUL_CHUNK = 16;
   localparam int MUL_STEPS = POS_W / MUL_CHUNK;
   localparam int PROD_W    = 2 * POS_W;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_P2M     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_M2P     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SHIFT   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_BTW     = 3'd5;
   localparam logic [CMD_W-1:0] CMD_BTW_EXC = 3'd6;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_ORDER = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] ST_FEW   = 2'd3;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_KEY_PB,
      OP_SAVE_LEFT,
      OP_KEY_TARGET,
      OP_SRCH_INIT,
      OP_SRCH_STEP,
      OP_RES_ZERO,
      OP_RES_CM,
      OP_MUL_LOAD,
      OP_MUL_STEP,
      OP_ROUND,
      OP_RES_ACC,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_PO_BP,
      OP_PO_DIV,
      OP_MO_RES,
      OP_MO_DIFF,
      OP_WRITE,
      OP_CLEAR,
      OP_ST_ORDER,
      OP_ST_FULL,
      OP_ST_FEW,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      RA_ZERO,
      RA_LAST,
      RA_MID,
      RA_K,
      RA_LO
   } rd_sel_type;

   typedef struct packed {
      op_type     op;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       srch_mass;
   } ctl_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             n_full;
      logic             n_zero;
      logic             n_lt2;
      logic             key_le_bp;
      logic             key_ge_bp;
      logic             key_ge_cm;
      logic             key_zero;
      logic             rate_zero;
      logic             lo_lt_hi;
      logic             lo_ge_n;
      logic             lo_zero;
      logic             mul_last;
      logic             div_last;
      logic             out_free;
   } sts_type;

endpackage

@@ rtl/core/cumulative_rate_map_lookup.sv @@
// Mass-to-pos divides bit-serially, one quotient bit per cycle; shift and
// between each chain two lookups; clear and rejected items go straight to
// the result. One word is in work at a time; the table search and the
// bit-serial divider set the rate. A new word is taken while a result
// waits. Reset empties the table and clears discrete mode; no clearing pass.
module cumulative_rate_map_lookup import crml_pkg::*; #(
   parameter int MAX_ENTRIES = 256,
   parameter int FRAC_BITS   = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // position_a, position_b, scaled_rate, mass_in
   input  logic [REQ_DW-1:0] req_tdata,
   // command
   input  logic [CMD_W-1:0]  req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // mass_out, position_out, zero pad
   output logic [RSP_DW-1:0] rsp_tdata,
   // status
   output logic [STAT_W-1:0] rsp_tuser,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   ctl_type ctl;
   sts_type sts;

   crml_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   crml_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ctl         (ctl),
      .sts         (sts),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

@@ rtl/core/crml_ctrl.sv @@
module crml_ctrl import crml_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output ctl_type ctl
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_LD_CK,
      S_P_RD0,
      S_P_CK0,
      S_P_CKL,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_P_SUB,
      S_P_MUL,
      S_P_RND,
      S_P_ACC,
      S_P_END,
      S_SH_CK,
      S_M_START,
      S_M_CHK,
      S_M_DIV,
      S_M_FIN,
      S_M_POS,
      S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      second_ff, second_in;
   logic      m2p_ff, m2p_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and datapath commands
   always_comb begin
      state_in      = state_ff;
      second_in     = second_ff;
      m2p_in        = m2p_ff;
      ctl.op        = OP_NONE;
      ctl.rd_en     = 1'b0;
      ctl.rd_sel    = RA_ZERO;
      ctl.srch_mass = m2p_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.op    = OP_CAPTURE;
               second_in = 1'b0;
               m2p_in    = 1'b0;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.cmd)
               CMD_LOAD: begin
                  if (sts.n_full) begin
                     ctl.op   = OP_ST_FULL;
                     state_in = S_FIN;
                  end else if (sts.n_zero) begin
                     ctl.op   = OP_RES_ZERO;
                     state_in = S_P_END;
                  end else begin
                     ctl.rd_en  = 1'b1;
                     ctl.rd_sel = RA_LAST;
                     state_in   = S_LD_CK;
                  end
               end
               CMD_CLEAR: begin
                  ctl.op   = OP_CLEAR;
                  state_in = S_FIN;
               end
               CMD_P2M, CMD_SHIFT, CMD_M2P, CMD_BTW, CMD_BTW_EXC: begin
                  if (sts.n_lt2) begin
                     ctl.op   = OP_ST_FEW;
                     state_in = S_FIN;
                  end else if (sts.cmd == CMD_M2P) begin
                     m2p_in   = 1'b1;
                     state_in = S_M_START;
                  end else begin
                     if (sts.cmd == CMD_BTW || sts.cmd == CMD_BTW_EXC) begin
                        ctl.op = OP_KEY_PB;
                     end
                     state_in = S_P_RD0;
                  end
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         // reject a breakpoint that is not above the last one
         S_LD_CK: begin
            if (sts.key_le_bp) begin
               ctl.op   = OP_ST_ORDER;
               state_in = S_FIN;
            end else begin
               state_in = S_P_SUB;
            end
         end
         S_P_RD0: begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = RA_ZERO;
            state_in   = S_P_CK0;
         end
         S_P_CK0: begin
            if (sts.key_le_bp) begin
               ctl.op   = OP_RES_ZERO;
               state_in = S_P_END;
            end else begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = RA_LAST;
               state_in   = S_P_CKL;
            end
         end
         S_P_CKL: begin
            if (sts.key_ge_bp) begin
               ctl.op   = OP_RES_CM;
               state_in = S_P_END;
            end else begin
               ctl.op   = OP_SRCH_INIT;
               state_in = S_SRCH_RD;
            end
         end
         // bisect-left: read the middle entry, then narrow the range
         S_SRCH_RD: begin
            ctl.rd_en = 1'b1;
            if (sts.lo_lt_hi) begin
               ctl.rd_sel = RA_MID;
               state_in   = S_SRCH_CMP;
            end else if (!m2p_ff) begin
               ctl.rd_sel = RA_K;
               state_in   = S_P_SUB;
            end else if (sts.lo_ge_n) begin
               ctl.rd_sel = RA_LAST;
               state_in   = S_M_POS;
            end else if (sts.lo_zero) begin
               ctl.rd_sel = RA_ZERO;
               state_in   = S_M_POS;
            end else begin
               ctl.rd_sel = RA_K;
               state_in   = S_M_CHK;
            end
         end
         S_SRCH_CMP: begin
            ctl.op   = OP_SRCH_STEP;
            state_in = S_SRCH_RD;
         end
         // interval mass: multiply, round, accumulate
         S_P_SUB: begin
            ctl.op   = OP_MUL_LOAD;
            state_in = S_P_MUL;
         end
         S_P_MUL: begin
            ctl.op = OP_MUL_STEP;
            if (sts.mul_last) begin
               state_in = S_P_RND;
            end
         end
         S_P_RND: begin
            ctl.op   = OP_ROUND;
            state_in = S_P_ACC;
         end
         S_P_ACC: begin
            ctl.op   = OP_RES_ACC;
            state_in = S_P_END;
         end
         // a mass is ready: finish per command
         S_P_END: begin
            case (sts.cmd)
               CMD_LOAD: begin
                  ctl.op   = OP_WRITE;
                  state_in = S_FIN;
               end
               CMD_SHIFT: begin
                  ctl.op     = OP_KEY_TARGET;
                  ctl.rd_en  = 1'b1;
                  ctl.rd_sel = RA_LAST;
                  state_in   = S_SH_CK;
               end
               CMD_BTW, CMD_BTW_EXC: begin
                  if (!second_ff) begin
                     ctl.op    = OP_SAVE_LEFT;
                     second_in = 1'b1;
                     state_in  = S_P_RD0;
                  end else begin
                     ctl.op   = OP_MO_DIFF;
                     state_in = S_FIN;
                  end
               end
               default: begin
                  ctl.op   = OP_MO_RES;
                  state_in = S_FIN;
               end
            endcase
         end
         // clamp a shift that reaches the end
         S_SH_CK: begin
            if (sts.key_ge_cm) begin
               ctl.op   = OP_PO_BP;
               state_in = S_FIN;
            end else begin
               m2p_in   = 1'b1;
               state_in = S_M_START;
            end
         end
         S_M_START: begin
            if (sts.key_zero) begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = RA_ZERO;
               state_in   = S_M_POS;
            end else begin
               ctl.op        = OP_SRCH_INIT;
               ctl.srch_mass = 1'b1;
               state_in      = S_SRCH_RD;
            end
         end
         S_M_CHK: begin
            if (sts.rate_zero) begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = RA_LO;
               state_in   = S_M_POS;
            end else begin
               ctl.op   = OP_DIV_LOAD;
               state_in = S_M_DIV;
            end
         end
         S_M_DIV: begin
            ctl.op = OP_DIV_STEP;
            if (sts.div_last) begin
               state_in = S_M_FIN;
            end
         end
         S_M_FIN: begin
            ctl.op   = OP_PO_DIV;
            state_in = S_FIN;
         end
         S_M_POS: begin
            ctl.op   = OP_PO_BP;
            state_in = S_FIN;
         end
         // hand the word to the output register once it is free
         S_FIN: begin
            if (sts.out_free) begin
               ctl.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         second_ff <= 1'b0;
         m2p_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
         m2p_ff    <= m2p_in;
      end
   end

endmodule

@@ rtl/core/crml_dp.sv @@
module crml_dp import crml_pkg::*; #(
   parameter int MAX_ENTRIES = 256,
   parameter int FRAC_BITS   = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [REQ_DW-1:0] req_tdata,
   input  logic [CMD_W-1:0]  req_tuser,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  ctl_type           ctl,
   output sts_type           sts,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,
   output logic [STAT_W-1:0] rsp_tuser
);

   localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW  = $clog2(MAX_ENTRIES + 1);
   localparam int NW  = MASS_W + 2 * FRAC_BITS;
   localparam int DCW = $clog2(NW);
   localparam logic [PROD_W:0] RND_HALF =
      (FRAC_BITS == 0) ? '0 : ((PROD_W + 1)'(1) << (2 * FRAC_BITS - 1));
   localparam logic [POS_W-1:0] FLOOR_MASK =
      ~((POS_W'(1) << FRAC_BITS) - POS_W'(1));
   localparam logic [POS_W:0] UNIT = (POS_W + 1)'(1) << FRAC_BITS;

   // tables
   logic [POS_W-1:0]  bp_mem [MAX_ENTRIES];
   logic [POS_W-1:0]  rt_mem [MAX_ENTRIES];
   logic [MASS_W-1:0] cm_mem [MAX_ENTRIES];

   logic [POS_W-1:0]  bp_rd_ff, rt_rd_ff;
   logic [MASS_W-1:0] cm_rd_ff;

   // control registers
   logic [CW-1:0] n_ff;
   logic          disc_ff;
   logic          rsp_valid_ff;

   // working registers
   logic [CMD_W-1:0]  cmd_ff;
   logic [POS_W-1:0]  pa_ff, pb_ff, rate_ff;
   logic [MASS_W-1:0] mass_ff;
   logic [MO_W-1:0]   key_ff;
   logic [CW-1:0]     lo_ff, hi_ff;
   logic [POS_W-1:0]  ma_ff, mb_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [1:0]        mcnt_ff;
   logic [MASS_W-1:0] imass_ff, res_ff, m1_ff;
   logic [NW-1:0]     num_ff;
   logic [POS_W-1:0]  rem_ff, q_ff;
   logic              over_ff;
   logic [DCW-1:0]    dcnt_ff;
   logic [STAT_W-1:0] status_ff, rsp_status_ff;
   logic [MO_W-1:0]   mo_ff, rsp_mo_ff;
   logic [POS_W-1:0]  po_ff, rsp_po_ff;

   // derived values
   logic [CW:0]          mid_sum;
   logic [CW-1:0]        mid;
   logic [CW-1:0]        n_m1, lo_m1;
   logic [AW-1:0]        rd_addr;
   logic [MASS_W-1:0]    srch_data;
   logic [2*MUL_CHUNK+POS_W-MUL_CHUNK-1:0] part;
   logic [PROD_W:0]      rnd;
   logic [PROD_W:0]      rnd_sh;
   logic [MASS_W:0]      acc_sum;
   logic [POS_W:0]       left_sum;
   logic [POS_W-1:0]     left;
   logic [POS_W:0]       rem_sh;
   logic                 qbit;
   logic [POS_W:0]       psum;
   logic [POS_W-1:0]     pdiv;
   logic                 wr;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CW:1];
   assign n_m1    = n_ff - CW'(1);
   assign lo_m1   = lo_ff - CW'(1);

   // pick the read address
   always_comb begin
      case (ctl.rd_sel)
         RA_LAST: rd_addr = n_m1[AW-1:0];
         RA_MID:  rd_addr = mid[AW-1:0];
         RA_K:    rd_addr = lo_m1[AW-1:0];
         RA_LO:   rd_addr = lo_ff[AW-1:0];
         default: rd_addr = '0;
      endcase
   end

   assign wr = (ctl.op == OP_WRITE);

   always_ff @(posedge clock) begin
      if (wr) begin
         bp_mem[n_ff[AW-1:0]] <= pa_ff;
         rt_mem[n_ff[AW-1:0]] <= rate_ff;
         cm_mem[n_ff[AW-1:0]] <= res_ff;
      end
      if (ctl.rd_en) begin
         bp_rd_ff <= bp_mem[rd_addr];
         rt_rd_ff <= rt_mem[rd_addr];
         cm_rd_ff <= cm_mem[rd_addr];
      end
   end

   // arithmetic
   assign srch_data = ctl.srch_mass ? cm_rd_ff : MASS_W'(bp_rd_ff);
   assign part      = ma_ff * mb_ff[mcnt_ff*MUL_CHUNK +: MUL_CHUNK];
   assign rnd       = {1'b0, prod_ff} + RND_HALF;
   assign rnd_sh    = rnd >> (2 * FRAC_BITS);
   assign acc_sum   = {1'b0, cm_rd_ff} + {1'b0, imass_ff};
   assign left_sum  = {1'b0, pa_ff} + UNIT;
   assign rem_sh    = {rem_ff, num_ff[NW-1]};
   assign qbit      = (rem_sh >= {1'b0, rt_rd_ff});
   assign psum      = {1'b0, bp_rd_ff} + {1'b0, q_ff};

   always_comb begin
      if (cmd_ff == CMD_BTW_EXC && disc_ff) begin
         left = left_sum[POS_W] ? '1 : left_sum[POS_W-1:0];
      end else begin
         left = pa_ff;
      end
      pdiv = (over_ff || psum[POS_W]) ? '1 : psum[POS_W-1:0];
      if (disc_ff) begin
         pdiv = pdiv & FLOOR_MASK;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         disc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            disc_ff <= csr_wr_data;
         end
         if (ctl.op == OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (ctl.op)
            OP_WRITE: n_ff <= n_ff + CW'(1);
            OP_CLEAR: n_ff <= '0;
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_CAPTURE: begin
            cmd_ff    <= req_tuser;
            pa_ff     <= req_tdata[47:0];
            pb_ff     <= req_tdata[95:48];
            rate_ff   <= req_tdata[143:96];
            mass_ff   <= req_tdata[199:144];
            key_ff    <= (req_tuser == CMD_M2P) ? MO_W'(req_tdata[199:144])
                                                : MO_W'(req_tdata[47:0]);
            status_ff <= ST_OK;
            mo_ff     <= '0;
            po_ff     <= '0;
         end
         OP_KEY_PB:     key_ff <= MO_W'(pb_ff);
         OP_SAVE_LEFT: begin
            m1_ff  <= res_ff;
            key_ff <= MO_W'(left);
         end
         OP_KEY_TARGET: key_ff <= {1'b0, res_ff} + {1'b0, mass_ff};
         OP_SRCH_INIT: begin
            lo_ff <= '0;
            hi_ff <= n_ff;
         end
         OP_SRCH_STEP: begin
            if (MO_W'(srch_data) < key_ff) begin
               lo_ff <= mid + CW'(1);
            end else begin
               hi_ff <= mid;
            end
         end
         OP_RES_ZERO: res_ff <= '0;
         OP_RES_CM:   res_ff <= cm_rd_ff;
         OP_MUL_LOAD: begin
            ma_ff   <= key_ff[POS_W-1:0] - bp_rd_ff;
            mb_ff   <= rt_rd_ff;
            prod_ff <= '0;
            mcnt_ff <= '0;
         end
         OP_MUL_STEP: begin
            prod_ff <= prod_ff + (PROD_W'(part) << (MUL_CHUNK * mcnt_ff));
            mcnt_ff <= mcnt_ff + 2'd1;
         end
         OP_ROUND: begin
            imass_ff <= (|rnd_sh[PROD_W:MASS_W]) ? '1 : rnd_sh[MASS_W-1:0];
         end
         OP_RES_ACC: res_ff <= acc_sum[MASS_W] ? '1 : acc_sum[MASS_W-1:0];
         OP_DIV_LOAD: begin
            num_ff  <= NW'(key_ff[MASS_W-1:0] - cm_rd_ff) << (2 * FRAC_BITS);
            rem_ff  <= '0;
            q_ff    <= '0;
            over_ff <= 1'b0;
            dcnt_ff <= DCW'(NW - 1);
         end
         OP_DIV_STEP: begin
            rem_ff  <= qbit ? POS_W'(rem_sh - {1'b0, rt_rd_ff}) : rem_sh[POS_W-1:0];
            q_ff    <= {q_ff[POS_W-2:0], qbit};
            over_ff <= over_ff | (qbit && (dcnt_ff >= DCW'(POS_W)));
            num_ff  <= num_ff << 1;
            dcnt_ff <= dcnt_ff - DCW'(1);
         end
         OP_PO_BP:    po_ff <= bp_rd_ff;
         OP_PO_DIV:   po_ff <= pdiv;
         OP_MO_RES:   mo_ff <= {1'b0, res_ff};
         OP_MO_DIFF:  mo_ff <= {1'b0, m1_ff} - {1'b0, res_ff};
         OP_WRITE:    mo_ff <= {1'b0, res_ff};
         OP_ST_ORDER: status_ff <= ST_ORDER;
         OP_ST_FULL:  status_ff <= ST_FULL;
         OP_ST_FEW:   status_ff <= ST_FEW;
         OP_EMIT: begin
            rsp_status_ff <= status_ff;
            rsp_mo_ff     <= mo_ff;
            rsp_po_ff     <= po_ff;
         end
         default: ;
      endcase
   end

   // status toward the controller
   always_comb begin
      sts.cmd       = cmd_ff;
      sts.n_full    = (n_ff == CW'(MAX_ENTRIES));
      sts.n_zero    = (n_ff == '0);
      sts.n_lt2     = (n_ff < CW'(2));
      sts.key_le_bp = (key_ff <= MO_W'(bp_rd_ff));
      sts.key_ge_bp = (key_ff >= MO_W'(bp_rd_ff));
      sts.key_ge_cm = (key_ff >= MO_W'(cm_rd_ff));
      sts.key_zero  = (key_ff == '0);
      sts.rate_zero = (rt_rd_ff == '0);
      sts.lo_lt_hi  = (lo_ff < hi_ff);
      sts.lo_ge_n   = (lo_ff >= n_ff);
      sts.lo_zero   = (lo_ff == '0);
      sts.mul_last  = (mcnt_ff == 2'(MUL_STEPS - 1));
      sts.div_last  = (dcnt_ff == '0);
      sts.out_free  = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DW - MO_W - POS_W){1'b0}}, rsp_po_ff, rsp_mo_ff};

endmodule
